### hw/rtl/xlvd_pkg.sv
`timescale 1ns / 1ps

package xlvd_pkg;

  // Fixed field widths of the ports.
  localparam int SITE_W     = 12;
  localparam int IN_ANGLE_W = 16;
  localparam int CLASS_W    = 2;
  localparam int SUM_W      = 19;
  localparam int LOG_CFG_W  = 3;
  localparam int TOL_W      = 15;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;

  // Request commands.
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Vortex classes.
  localparam logic [CLASS_W-1:0] CLS_NONE = 2'd0;
  localparam logic [CLASS_W-1:0] CLS_CCW  = 2'd1;
  localparam logic [CLASS_W-1:0] CLS_CW   = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_LOG_SIZE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE    = 2'd2;

  // Configuration reset values.
  localparam logic [LOG_CFG_W-1:0] LOG_SIZE_RST  = 3'd6;
  localparam logic [TOL_W-1:0]     TOLERANCE_RST = 15'd6554;
  localparam logic                 ENABLE_RST    = 1'b0;

  // Detection settings handed to the plaquette pipeline.
  typedef struct packed {
    logic [TOL_W-1:0] tolerance;
    logic             enable;
  } detect_cfg_t;

  // Tag that travels with a request through the pipeline.
  typedef struct packed {
    logic              cmd;
    logic [SITE_W-1:0] site;
  } item_tag_t;

endpackage

### hw/rtl/xlvd_spin_bank.sv
`timescale 1ns / 1ps

module xlvd_spin_bank #(
  parameter int ADDR_W = 11,
  parameter int DATA_W = 16
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr_a,
  input  logic [ADDR_W-1:0] rd_addr_b,
  output logic [DATA_W-1:0] rd_data_a,
  output logic [DATA_W-1:0] rd_data_b
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  // One write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Two registered read ports; the data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

### hw/rtl/xlvd_plaquette.sv
`timescale 1ns / 1ps

module xlvd_plaquette
  import xlvd_pkg::*;
#(
  parameter int ANGLE_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv,
  input  logic                         in_valid,
  input  item_tag_t                    in_tag,
  input  logic [3:0][ANGLE_BITS-1:0]   corner_angle,
  input  detect_cfg_t                  cfg,
  output logic                         out_valid,
  output logic [CLASS_W-1:0]           out_vortex_class,
  output logic signed [SUM_W-1:0]      out_winding_sum,
  output logic [SITE_W-1:0]            out_queried_site
);

  localparam int SW = ANGLE_BITS + 3;
  localparam int CW = ((ANGLE_BITS > TOL_W) ? ANGLE_BITS : TOL_W) + 3;
  localparam logic signed [CW-1:0] TURN_C =
    {{(CW - ANGLE_BITS - 1){1'b0}}, 1'b1, {ANGLE_BITS{1'b0}}};

  // Stage one: the four shortest signed differences around the plaquette.
  logic [ANGLE_BITS-1:0]   d_raw      [4];
  logic signed [ANGLE_BITS:0] diff_nxt [4];
  logic signed [ANGLE_BITS:0] diff_r   [4];
  logic                    v1_r;
  item_tag_t               tag1_r;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      d_raw[k]    = corner_angle[(k + 1) % 4] - corner_angle[k];
      // Above half a turn the difference wraps to the negative side.
      diff_nxt[k] = {d_raw[k][ANGLE_BITS-1] & (|d_raw[k][ANGLE_BITS-2:0]), d_raw[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tag1_r <= in_tag;
      for (int k = 0; k < 4; k++) begin
        diff_r[k] <= diff_nxt[k];
      end
    end
  end

  // Stage two: winding sum and the common-sign test.
  logic signed [SW-1:0] sum_nxt;
  logic signed [SW-1:0] sum_r;
  logic                 same_nxt;
  logic                 same_r;
  logic                 v2_r;
  item_tag_t            tag2_r;

  always_comb begin
    sum_nxt = SW'(diff_r[0]) + SW'(diff_r[1]) + SW'(diff_r[2]) + SW'(diff_r[3]);
    if (!diff_r[0][ANGLE_BITS]) begin
      same_nxt = !diff_r[1][ANGLE_BITS] && !diff_r[2][ANGLE_BITS] &&
                 !diff_r[3][ANGLE_BITS];
    end else begin
      same_nxt = (diff_r[1][ANGLE_BITS] || (diff_r[1] == '0)) &&
                 (diff_r[2][ANGLE_BITS] || (diff_r[2] == '0)) &&
                 (diff_r[3][ANGLE_BITS] || (diff_r[3] == '0));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tag2_r <= tag1_r;
      sum_r  <= sum_nxt;
      same_r <= same_nxt;
    end
  end

  // Stage three: window test against one full turn and the output register.
  logic signed [CW-1:0]    sum_c;
  logic signed [CW-1:0]    nsum_c;
  logic signed [CW-1:0]    tol_c;
  logic signed [CW-1:0]    win_lo;
  logic signed [CW-1:0]    win_hi;
  logic [SW+SUM_W-1:0]     sum_wide;
  logic [CLASS_W-1:0]      class_nxt;
  logic signed [SUM_W-1:0] osum_nxt;
  logic                    out_valid_r;
  logic [CLASS_W-1:0]      out_class_r;
  logic signed [SUM_W-1:0] out_sum_r;
  logic [SITE_W-1:0]       out_site_r;

  always_comb begin
    sum_c    = CW'(sum_r);
    nsum_c   = -sum_c;
    tol_c    = {{(CW - TOL_W){1'b0}}, cfg.tolerance};
    win_lo   = TURN_C - tol_c;
    win_hi   = TURN_C + tol_c;
    sum_wide = {{SUM_W{sum_r[SW-1]}}, sum_r};
    class_nxt = CLS_NONE;
    osum_nxt  = '0;
    if (tag2_r.cmd == CMD_QUERY) begin
      osum_nxt = sum_wide[SUM_W-1:0];
      if (cfg.enable && same_r) begin
        if (sum_c > win_lo && sum_c <= win_hi) begin
          class_nxt = CLS_CCW;
        end else if (nsum_c > win_lo && nsum_c <= win_hi) begin
          class_nxt = CLS_CW;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_class_r <= class_nxt;
      out_sum_r   <= osum_nxt;
      out_site_r  <= tag2_r.site;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_vortex_class = out_class_r;
  assign out_winding_sum  = out_sum_r;
  assign out_queried_site = out_site_r;

  // A counter-clockwise vortex always carries a positive winding sum.
  a_ccw_positive: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && v2_r && class_nxt == CLS_CCW) |=> (out_sum_r > 0))
    else $error("counter-clockwise result with non-positive sum");

  // A clockwise vortex always carries a negative winding sum.
  a_cw_negative: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && v2_r && class_nxt == CLS_CW) |=> (out_sum_r < 0))
    else $error("clockwise result with non-negative sum");

endmodule

### hw/rtl/xy_lattice_vortex_detector.sv
`timescale 1ns / 1ps

// Channel  Handshake               Payload
// in       in_valid / in_ready     in_cmd, in_site_index, in_spin_angle
// out      out_valid / out_ready   out_vortex_class, out_winding_sum, out_queried_site
// cfg      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One request is taken per cycle while the output is not stalled.
// The rate is set by the two spin banks, split by column parity, each read at two ports.
// rst_n is synchronous: it clears the pipeline and the registers, not the spin store.
// A result waiting at the output holds the whole pipeline; in_ready then stays low.
// in_ready and cfg_ready are low during reset; cfg_ready is otherwise always high.
module xy_lattice_vortex_detector
  import xlvd_pkg::*;
#(
  parameter int LOG_MAX_SIDE = 6,
  parameter int ANGLE_BITS   = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_cmd,
  input  logic [SITE_W-1:0]       in_site_index,
  input  logic [IN_ANGLE_W-1:0]   in_spin_angle,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [CLASS_W-1:0]      out_vortex_class,
  output logic signed [SUM_W-1:0] out_winding_sum,
  output logic [SITE_W-1:0]       out_queried_site,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data
);

  localparam int L       = LOG_MAX_SIDE;
  localparam int ABITS   = 2 * L;
  localparam int BANK_AW = ABITS - 1;
  localparam int LW      = $clog2(LOG_MAX_SIDE + 1);

  // Configuration registers.
  logic [LOG_CFG_W-1:0] lattice_log_size_r;
  logic [TOL_W-1:0]     winding_tolerance_r;
  logic                 detect_enable_r;

  assign cfg_ready = rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lattice_log_size_r  <= LOG_SIZE_RST;
      winding_tolerance_r <= TOLERANCE_RST;
      detect_enable_r     <= ENABLE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_LOG_SIZE:  lattice_log_size_r  <= cfg_data[LOG_CFG_W-1:0];
        CFG_TOLERANCE: winding_tolerance_r <= cfg_data[TOL_W-1:0];
        CFG_ENABLE:    detect_enable_r     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Effective side log, clamped to the supported range.
  logic [LW-1:0] eff_log;

  always_comb begin
    if (lattice_log_size_r == '0) begin
      eff_log = LW'(1);
    end else if (int'(lattice_log_size_r) > LOG_MAX_SIDE) begin
      eff_log = LW'(LOG_MAX_SIDE);
    end else begin
      eff_log = LW'(lattice_log_size_r);
    end
  end

  // Plaquette corner addresses with wrap-around.
  logic [SITE_W+ABITS-1:0]     site_wide;
  logic [ABITS-1:0]            site_ext;
  logic [ABITS-1:0]            row_shift;
  logic [L-1:0]                side_mask;
  logic [L-1:0]                col;
  logic [L-1:0]                row;
  logic [L-1:0]                down_row;
  logic [L-1:0]                right_col;
  logic [ABITS-1:0]            addr_here;
  logic [ABITS-1:0]            addr_down;
  logic [ABITS-1:0]            addr_dr;
  logic [ABITS-1:0]            addr_right;
  logic [IN_ANGLE_W+ANGLE_BITS-1:0] angle_wide;
  logic [ANGLE_BITS-1:0]       wr_angle;

  always_comb begin
    site_wide  = {{ABITS{1'b0}}, in_site_index};
    site_ext   = site_wide[ABITS-1:0];
    side_mask  = ~({L{1'b1}} << eff_log);
    col        = site_ext[L-1:0] & side_mask;
    row_shift  = site_ext >> eff_log;
    row        = row_shift[L-1:0] & side_mask;
    down_row   = (row + L'(1)) & side_mask;
    right_col  = (col + L'(1)) & side_mask;
    addr_here  = (ABITS'(row) << eff_log) | ABITS'(col);
    addr_down  = (ABITS'(down_row) << eff_log) | ABITS'(col);
    addr_dr    = (ABITS'(down_row) << eff_log) | ABITS'(right_col);
    addr_right = (ABITS'(row) << eff_log) | ABITS'(right_col);
    angle_wide = {{ANGLE_BITS{1'b0}}, in_spin_angle};
    wr_angle   = angle_wide[ANGLE_BITS-1:0];
  end

  // Request acceptance and bank control.
  logic adv;
  logic accept;
  logic wr_en;
  logic rd_en;
  logic even_we;
  logic odd_we;

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv && rst_n;
  assign accept   = in_valid && in_ready;
  assign wr_en    = accept && (in_cmd == CMD_WRITE);
  assign rd_en    = accept && (in_cmd == CMD_QUERY);
  assign even_we  = wr_en && !addr_here[0];
  assign odd_we   = wr_en && addr_here[0];

  // The site and the site below share a column parity; the other two take the other bank.
  logic [BANK_AW-1:0]    even_ra;
  logic [BANK_AW-1:0]    even_rb;
  logic [BANK_AW-1:0]    odd_ra;
  logic [BANK_AW-1:0]    odd_rb;
  logic [ANGLE_BITS-1:0] even_da;
  logic [ANGLE_BITS-1:0] even_db;
  logic [ANGLE_BITS-1:0] odd_da;
  logic [ANGLE_BITS-1:0] odd_db;

  always_comb begin
    if (col[0]) begin
      even_ra = addr_right[ABITS-1:1];
      even_rb = addr_dr[ABITS-1:1];
      odd_ra  = addr_here[ABITS-1:1];
      odd_rb  = addr_down[ABITS-1:1];
    end else begin
      even_ra = addr_here[ABITS-1:1];
      even_rb = addr_down[ABITS-1:1];
      odd_ra  = addr_right[ABITS-1:1];
      odd_rb  = addr_dr[ABITS-1:1];
    end
  end

  xlvd_spin_bank #(
    .ADDR_W (BANK_AW),
    .DATA_W (ANGLE_BITS)
  ) u_even_bank (
    .clk       (clk),
    .wr_en     (even_we),
    .wr_addr   (addr_here[ABITS-1:1]),
    .wr_data   (wr_angle),
    .rd_en     (rd_en),
    .rd_addr_a (even_ra),
    .rd_addr_b (even_rb),
    .rd_data_a (even_da),
    .rd_data_b (even_db)
  );

  xlvd_spin_bank #(
    .ADDR_W (BANK_AW),
    .DATA_W (ANGLE_BITS)
  ) u_odd_bank (
    .clk       (clk),
    .wr_en     (odd_we),
    .wr_addr   (addr_here[ABITS-1:1]),
    .wr_data   (wr_angle),
    .rd_en     (rd_en),
    .rd_addr_a (odd_ra),
    .rd_addr_b (odd_rb),
    .rd_data_a (odd_da),
    .rd_data_b (odd_db)
  );

  // Read stage: request tag alongside the bank read.
  logic      s0_valid_r;
  item_tag_t s0_tag_r;
  logic      s0_swap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (adv) begin
      s0_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s0_tag_r.cmd  <= in_cmd;
      s0_tag_r.site <= in_site_index;
      s0_swap_r     <= col[0];
    end
  end

  // Corners in walk order: site, below, below-right, right.
  logic [3:0][ANGLE_BITS-1:0] corner_angle;
  detect_cfg_t                det_cfg;

  always_comb begin
    if (s0_swap_r) begin
      corner_angle[0] = odd_da;
      corner_angle[1] = odd_db;
      corner_angle[2] = even_db;
      corner_angle[3] = even_da;
    end else begin
      corner_angle[0] = even_da;
      corner_angle[1] = even_db;
      corner_angle[2] = odd_db;
      corner_angle[3] = odd_da;
    end
    det_cfg.tolerance = winding_tolerance_r;
    det_cfg.enable    = detect_enable_r;
  end

  xlvd_plaquette #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_plaquette (
    .clk              (clk),
    .rst_n            (rst_n),
    .adv              (adv),
    .in_valid         (s0_valid_r),
    .in_tag           (s0_tag_r),
    .corner_angle     (corner_angle),
    .cfg              (det_cfg),
    .out_valid        (out_valid),
    .out_vortex_class (out_vortex_class),
    .out_winding_sum  (out_winding_sum),
    .out_queried_site (out_queried_site)
  );

  // A write lands in exactly one bank.
  a_one_bank_write: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (even_we ^ odd_we))
    else $error("write request not steered to exactly one bank");

  // A result held at the output blocks new requests.
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("request accepted while the output is stalled");

  // A request in the read stage keeps its tag while the pipeline is held.
  a_read_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s0_valid_r && !adv) |=> (s0_valid_r && $stable(s0_tag_r) && $stable(s0_swap_r)))
    else $error("read stage lost its request during a stall");

endmodule
